[rtl/core/jdas_pkg.sv]
// Package for the joystick deadzone axis scaler: widths, register indexes,
// reset calibration and the per-axis calibration record.
// No dependencies.
package jdas_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int AXIS_LIMIT     = 127;
  localparam int AXIS_BITS      = 8;
  localparam int NUM_AXES       = 2;

  // Quotient is saturated above AXIS_LIMIT, so only this many bits are resolved
  localparam int QUO_BITS       = $clog2(AXIS_LIMIT + 1);
  localparam int OFF_BITS       = SAMPLE_BITS + 1;
  localparam int NUM_BITS       = SAMPLE_BITS + QUO_BITS;
  localparam int SQ_BITS        = 2 * SAMPLE_BITS;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = SAMPLE_BITS;
  localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 2 * AXIS_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE,
    REG_DZ_RADIUS,
    REG_X_NEG_END,
    REG_X_CENTER,
    REG_X_POS_END,
    REG_Y_NEG_END,
    REG_Y_CENTER,
    REG_Y_POS_END
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] neg_end;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] pos_end;
  } axis_cal_t;

  localparam logic                   RST_ENABLE    = 1'b1;
  localparam logic [SAMPLE_BITS-1:0] RST_DZ_RADIUS = SAMPLE_BITS'(64);
  localparam axis_cal_t RST_X_CAL = '{neg_end: SAMPLE_BITS'(784),
                                      center:  SAMPLE_BITS'(444),
                                      pos_end: SAMPLE_BITS'(172)};
  localparam axis_cal_t RST_Y_CAL = '{neg_end: SAMPLE_BITS'(244),
                                      center:  SAMPLE_BITS'(532),
                                      pos_end: SAMPLE_BITS'(822)};

endpackage

[rtl/core/joystick_deadzone_axis_scaler.sv]
// Top level of the joystick deadzone axis scaler: calibration registers,
// deadzone test and a pipelined restoring divider per axis.
// Depends on jdas_pkg.

// While the output is not stalled, one X/Y sample pair enters per clock, its pair
// of signed axis values leaves through the stages below, and the sustained rate is
// one word per cycle. The pipeline has three set-up stages (centre offsets; squares
// and scaled numerators; deadzone test and divisor choice), then one stage per
// quotient bit of a restoring divider (seven for a limit of 127), then the output
// register. Each stage has its own valid bit and a stage holds only when it is
// full and the one after it cannot take its word, so bubbles squeeze out during a
// stall and a waiting result does not block input until the pipeline is full.
// Calibration and enable are plain write-only registers; write them only while
// the pipeline is empty.
module joystick_deadzone_axis_scaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [jdas_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [jdas_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // sample stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [jdas_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // raw_x, raw_y, zero pad
  // axis stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [jdas_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata    // axis_x, axis_y
);
  import jdas_pkg::*;

  localparam int NUM_STAGES = 3 + QUO_BITS + 1;
  localparam int ST_DIV     = 3;
  localparam int ST_OUT     = NUM_STAGES - 1;
  localparam logic [QUO_BITS-1:0]  LIMIT_Q   = QUO_BITS'(AXIS_LIMIT);
  localparam logic [AXIS_BITS-1:0] LIMIT_OUT = AXIS_BITS'(AXIS_LIMIT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                   enable_q;
  logic [SAMPLE_BITS-1:0] radius_q;
  axis_cal_t              cal_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= RST_ENABLE;
      radius_q <= RST_DZ_RADIUS;
      cal_q[0] <= RST_X_CAL;
      cal_q[1] <= RST_Y_CAL;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:    enable_q           <= cfg_data_i[0];
        REG_DZ_RADIUS: radius_q           <= cfg_data_i;
        REG_X_NEG_END: cal_q[0].neg_end   <= cfg_data_i;
        REG_X_CENTER:  cal_q[0].center    <= cfg_data_i;
        REG_X_POS_END: cal_q[0].pos_end   <= cfg_data_i;
        REG_Y_NEG_END: cal_q[1].neg_end   <= cfg_data_i;
        REG_Y_CENTER:  cal_q[1].center    <= cfg_data_i;
        REG_Y_POS_END: cal_q[1].pos_end   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-stage flow control: a stage advances when empty or when the next
  // stage advances too.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = valid_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: offsets from the calibrated centres
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]     raw [NUM_AXES];
  logic signed [OFF_BITS-1:0] dx_d [NUM_AXES];
  logic signed [OFF_BITS-1:0] dx_q [NUM_AXES];

  assign raw[0] = s_axis_tdata[SAMPLE_BITS-1:0];
  assign raw[1] = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dx_d[a] = $signed({1'b0, raw[a]}) - $signed({1'b0, cal_q[a].center});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: squares for the radial test and |offset| * limit
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] absdx   [NUM_AXES];
  logic [SQ_BITS-1:0]     sq_d    [NUM_AXES];
  logic [NUM_BITS-1:0]    mag1_d  [NUM_AXES];
  logic [SQ_BITS-1:0]     sq_q    [NUM_AXES];
  logic [NUM_BITS-1:0]    mag1_q  [NUM_AXES];
  logic                   nneg1_q [NUM_AXES];
  logic                   nz1_q   [NUM_AXES];
  logic [SQ_BITS-1:0]     rsq_d;
  logic [SQ_BITS-1:0]     rsq_q;
  logic signed [OFF_BITS-1:0] negdx [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      negdx[a]  = -dx_q[a];
      absdx[a]  = dx_q[a][OFF_BITS-1] ? negdx[a][SAMPLE_BITS-1:0] : dx_q[a][SAMPLE_BITS-1:0];
      sq_d[a]   = SQ_BITS'(absdx[a]) * SQ_BITS'(absdx[a]);
      mag1_d[a] = NUM_BITS'(absdx[a]) * NUM_BITS'(LIMIT_Q);
    end
    rsq_d = SQ_BITS'(radius_q) * SQ_BITS'(radius_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: deadzone test, divisor choice, saturation check
  // ---------------------------------------------------------------------------
  logic [SQ_BITS:0]           len2;
  logic                       in_dz;
  logic signed [OFF_BITS-1:0] div1   [NUM_AXES];
  logic signed [OFF_BITS-1:0] div2   [NUM_AXES];
  logic signed [OFF_BITS-1:0] dsel   [NUM_AXES];
  logic signed [OFF_BITS-1:0] ndiv1  [NUM_AXES];
  logic signed [OFF_BITS-1:0] ndsel  [NUM_AXES];
  logic [SAMPLE_BITS-1:0]     adiv1  [NUM_AXES];
  logic [SAMPLE_BITS-1:0]     dmag_d [NUM_AXES];
  logic                       pos1   [NUM_AXES];
  logic                       neg_d  [NUM_AXES];
  logic                       zero_d [NUM_AXES];
  logic                       sat_d  [NUM_AXES];

  always_comb begin
    len2  = (SQ_BITS+1)'(sq_q[0]) + (SQ_BITS+1)'(sq_q[1]);
    in_dz = len2 < {1'b0, rsq_q};
    for (int a = 0; a < NUM_AXES; a++) begin
      div1[a]  = $signed({1'b0, cal_q[a].center}) - $signed({1'b0, cal_q[a].neg_end});
      div2[a]  = $signed({1'b0, cal_q[a].pos_end}) - $signed({1'b0, cal_q[a].center});
      ndiv1[a] = -div1[a];
      adiv1[a] = div1[a][OFF_BITS-1] ? ndiv1[a][SAMPLE_BITS-1:0] : div1[a][SAMPLE_BITS-1:0];
      // first quotient is positive: non-zero, same signs, magnitude reaches one
      pos1[a]  = (div1[a] != '0) && nz1_q[a] && (nneg1_q[a] == div1[a][OFF_BITS-1])
                 && (mag1_q[a] >= NUM_BITS'(adiv1[a]));
      dsel[a]  = pos1[a] ? div2[a] : div1[a];
      ndsel[a] = -dsel[a];
      dmag_d[a] = dsel[a][OFF_BITS-1] ? ndsel[a][SAMPLE_BITS-1:0]
                                      : dsel[a][SAMPLE_BITS-1:0];
      neg_d[a]  = nneg1_q[a] ^ dsel[a][OFF_BITS-1];
      zero_d[a] = !enable_q || in_dz || (dsel[a] == '0);
      sat_d[a]  = mag1_q[a] >= {dmag_d[a], QUO_BITS'(0)};
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, most significant first
  // ---------------------------------------------------------------------------
  logic [NUM_BITS-1:0]    rem_q  [QUO_BITS+1][NUM_AXES];
  logic [QUO_BITS-1:0]    quo_q  [QUO_BITS+1][NUM_AXES];
  logic [SAMPLE_BITS-1:0] dmag_q [QUO_BITS+1][NUM_AXES];
  logic                   neg_q  [QUO_BITS+1][NUM_AXES];
  logic                   zero_q [QUO_BITS+1][NUM_AXES];
  logic                   sat_q  [QUO_BITS+1][NUM_AXES];

  logic [NUM_BITS-1:0]    dsh    [QUO_BITS][NUM_AXES];
  logic                   take   [QUO_BITS][NUM_AXES];
  logic [NUM_BITS-1:0]    rem_d  [QUO_BITS][NUM_AXES];
  logic [QUO_BITS-1:0]    quo_d  [QUO_BITS][NUM_AXES];

  always_comb begin
    for (int j = 0; j < QUO_BITS; j++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        dsh[j][a]   = NUM_BITS'(dmag_q[j][a]) << (QUO_BITS - 1 - j);
        take[j][a]  = rem_q[j][a] >= dsh[j][a];
        rem_d[j][a] = take[j][a] ? (rem_q[j][a] - dsh[j][a]) : rem_q[j][a];
        quo_d[j][a] = quo_q[j][a];
        quo_d[j][a][QUO_BITS-1-j] = take[j][a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: apply sign, clamp to the limit, force zero
  // ---------------------------------------------------------------------------
  logic [AXIS_BITS-1:0] lim    [NUM_AXES];
  logic [AXIS_BITS-1:0] axis_d [NUM_AXES];
  logic [AXIS_BITS-1:0] axis_q [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lim[a] = (sat_q[QUO_BITS][a] || (quo_q[QUO_BITS][a] > LIMIT_Q))
               ? LIMIT_OUT : AXIS_BITS'(quo_q[QUO_BITS][a]);
      if (zero_q[QUO_BITS][a]) begin
        axis_d[a] = '0;
      end else if (neg_q[QUO_BITS][a]) begin
        axis_d[a] = ~lim[a] + AXIS_BITS'(1);
      end else begin
        axis_d[a] = lim[a];
      end
    end
  end

  assign m_axis_tdata = {axis_q[1], axis_q[0]};

  // ---------------------------------------------------------------------------
  // Payload registers: load whenever the stage advances
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int a = 0; a < NUM_AXES; a++) dx_q[a] <= dx_d[a];
    end
    if (adv[1]) begin
      rsq_q <= rsq_d;
      for (int a = 0; a < NUM_AXES; a++) begin
        sq_q[a]    <= sq_d[a];
        mag1_q[a]  <= mag1_d[a];
        nneg1_q[a] <= dx_q[a][OFF_BITS-1];
        nz1_q[a]   <= dx_q[a] != '0;
      end
    end
    if (adv[2]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        rem_q[0][a]  <= mag1_q[a];
        quo_q[0][a]  <= '0;
        dmag_q[0][a] <= dmag_d[a];
        neg_q[0][a]  <= neg_d[a];
        zero_q[0][a] <= zero_d[a];
        sat_q[0][a]  <= sat_d[a];
      end
    end
    for (int j = 0; j < QUO_BITS; j++) begin
      if (adv[ST_DIV+j]) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          rem_q[j+1][a]  <= rem_d[j][a];
          quo_q[j+1][a]  <= quo_d[j][a];
          dmag_q[j+1][a] <= dmag_q[j][a];
          neg_q[j+1][a]  <= neg_q[j][a];
          zero_q[j+1][a] <= zero_q[j][a];
          sat_q[j+1][a]  <= sat_q[j][a];
        end
      end
    end
    if (adv[ST_OUT]) begin
      for (int a = 0; a < NUM_AXES; a++) axis_q[a] <= axis_d[a];
    end
  end

endmodule

[tb/joystick_deadzone_axis_scaler_tb.sv]
// Self-checking testbench for the joystick deadzone axis scaler: drives sample
// words, predicts each axis word and checks the output stream against it.
// Depends on jdas_pkg and the joystick_deadzone_axis_scaler top level.
`timescale 1ns / 1ps

module joystick_deadzone_axis_scaler_tb;
  import jdas_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 30;     // comfortably above the eleven-stage latency
  localparam int MAX_REPORTS  = 10;

  // Output word as it sits on m_axis_tdata: axis_x in the low byte
  typedef struct packed {
    logic signed [AXIS_BITS-1:0] axis_y;
    logic signed [AXIS_BITS-1:0] axis_x;
  } axes_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;    // raw_x, raw_y, zero pad
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;    // axis_x, axis_y

  // Shadow copy of the calibration registers
  logic                   cal_enable;
  logic [SAMPLE_BITS-1:0] cal_radius;
  axis_cal_t              cal_x;
  axis_cal_t              cal_y;

  axes_t expected_axes_q[$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;

  // Idling controls shared between the sender, the receiver and the tests
  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  int sink_hold_cycles = 0;
  int sink_gap = 0;

  joystick_deadzone_axis_scaler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: give up if the run stalls far beyond its slowest legal length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Scale one axis: first against the negative span, and when that comes out
  // positive, again against the positive span; a zero span gives 0. Truncate
  // toward zero, then clamp to the axis limit.
  function automatic logic [AXIS_BITS-1:0] scale_axis_value(logic [SAMPLE_BITS-1:0] raw,
                                                            axis_cal_t cal);
    longint off;
    longint span;
    longint v;
    off  = longint'(raw) - longint'(cal.center);
    span = longint'(cal.center) - longint'(cal.neg_end);
    v    = (span != 0) ? (off * longint'(AXIS_LIMIT)) / span : longint'(0);
    if (v > 0) begin
      span = longint'(cal.pos_end) - longint'(cal.center);
      v    = (span != 0) ? (off * longint'(AXIS_LIMIT)) / span : longint'(0);
    end
    if (v < -longint'(AXIS_LIMIT)) v = -longint'(AXIS_LIMIT);
    if (v > longint'(AXIS_LIMIT))  v = longint'(AXIS_LIMIT);
    return v[AXIS_BITS-1:0];
  endfunction

  // Whole axis word for one sample pair under the current calibration
  function automatic axes_t predict_axes(logic [SAMPLE_BITS-1:0] raw_x,
                                         logic [SAMPLE_BITS-1:0] raw_y);
    axes_t  res;
    longint dx;
    longint dy;
    res = '0;
    if (!cal_enable) return res;
    dx = longint'(raw_x) - longint'(cal_x.center);
    dy = longint'(raw_y) - longint'(cal_y.center);
    // Strictly inside the circle reads as rest; on the radius is outside
    if (dx * dx + dy * dy < longint'(cal_radius) * longint'(cal_radius)) return res;
    res.axis_x = scale_axis_value(raw_x, cal_x);
    res.axis_y = scale_axis_value(raw_y, cal_y);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Checking: compare every accepted output word with the oldest prediction
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string field, logic signed [AXIS_BITS-1:0] exp_v,
                                 logic signed [AXIS_BITS-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
               field, cycle_count, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin : axis_checker
    axes_t got;
    axes_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = axes_t'(m_axis_tdata);
      if (expected_axes_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected output word at cycle %0d: x %0d y %0d",
                   cycle_count, got.axis_x, got.axis_y);
      end else begin
        want = expected_axes_q.pop_front();
        if (got.axis_x !== want.axis_x) report_mismatch("axis_x", want.axis_x, got.axis_x);
        if (got.axis_y !== want.axis_y) report_mismatch("axis_y", want.axis_y, got.axis_y);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: long hold-off first, then random idle bursts, else ready
  // ------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      sink_hold_cycles--;
    end else if (sink_gap > 0) begin
      m_axis_tready = 1'b0;
      sink_gap--;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      sink_gap = int'($urandom_range(1, 13)) - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Sender and register access; all of these start and end at a falling edge
  // ------------------------------------------------------------------------

  // Offer one sample word, hold it until taken, and record its prediction
  task automatic send_sample(logic [SAMPLE_BITS-1:0] raw_x, logic [SAMPLE_BITS-1:0] raw_y);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_TDATA_BITS'({raw_y, raw_x});
    do @(posedge clk_i); while (!s_axis_tready);
    expected_axes_q.push_back(predict_axes(raw_x, raw_y));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic drain_pipeline();
    s_axis_tvalid = 1'b0;
    while (expected_axes_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register and mirror it in the shadow copy; only call when idle
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      REG_ENABLE:    cal_enable    = data[0];
      REG_DZ_RADIUS: cal_radius    = data;
      REG_X_NEG_END: cal_x.neg_end = data;
      REG_X_CENTER:  cal_x.center  = data;
      REG_X_POS_END: cal_x.pos_end = data;
      REG_Y_NEG_END: cal_y.neg_end = data;
      REG_Y_CENTER:  cal_y.center  = data;
      REG_Y_POS_END: cal_y.pos_end = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_axis_cal(bit is_y, axis_cal_t cal);
    if (is_y) begin
      write_reg(REG_Y_NEG_END, cal.neg_end);
      write_reg(REG_Y_CENTER,  cal.center);
      write_reg(REG_Y_POS_END, cal.pos_end);
    end else begin
      write_reg(REG_X_NEG_END, cal.neg_end);
      write_reg(REG_X_CENTER,  cal.center);
      write_reg(REG_X_POS_END, cal.pos_end);
    end
  endtask

  // Pick a sample that lands near the interesting spots of one axis
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(axis_cal_t cal,
                                                         logic [SAMPLE_BITS-1:0] radius);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 1023);
      4, 5:       v = int'(cal.center) + int'($urandom_range(0, 2 * radius + 8))
                      - int'(radius) - 4;
      6:          v = int'(cal.neg_end) + int'($urandom_range(0, 16)) - 8;
      7:          v = int'(cal.pos_end) + int'($urandom_range(0, 16)) - 8;
      8:          v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
      default:    v = int'(cal.center);
    endcase
    if (v < 0)    v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Build one axis calibration: fully random, realistic, or with a flat span
  function automatic axis_cal_t random_axis_cal(int mode);
    axis_cal_t cal;
    int c;
    int lo;
    int hi;
    if (mode == 0) begin
      cal.neg_end = SAMPLE_BITS'($urandom_range(0, 1023));
      cal.center  = SAMPLE_BITS'($urandom_range(0, 1023));
      cal.pos_end = SAMPLE_BITS'($urandom_range(0, 1023));
      return cal;
    end
    c  = $urandom_range(300, 700);
    lo = c - int'($urandom_range(20, 300));
    hi = c + int'($urandom_range(20, 323));
    if ($urandom_range(0, 7) == 0) lo = 0;
    if ($urandom_range(0, 7) == 0) hi = 1023;
    cal.center = SAMPLE_BITS'(c);
    // Either wiring direction of the potentiometer
    if ($urandom_range(0, 1) != 0) begin
      cal.neg_end = SAMPLE_BITS'(lo);
      cal.pos_end = SAMPLE_BITS'(hi);
    end else begin
      cal.neg_end = SAMPLE_BITS'(hi);
      cal.pos_end = SAMPLE_BITS'(lo);
    end
    if (mode == 3) begin
      if ($urandom_range(0, 1) != 0) cal.neg_end = cal.center;
      else                           cal.pos_end = cal.center;
    end
    return cal;
  endfunction

  // Write every register with a fresh random setting
  task automatic random_calibration();
    logic [CFG_DATA_BITS-1:0] en_word;
    logic [CFG_DATA_BITS-1:0] radius;
    en_word = CFG_DATA_BITS'($urandom_range(0, 1023));
    // Mostly enabled, whatever the upper bits of the word hold
    en_word[0] = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 5))
      0:       radius = '0;
      1:       radius = '1;
      2:       radius = CFG_DATA_BITS'($urandom_range(0, 1023));
      default: radius = CFG_DATA_BITS'($urandom_range(0, 200));
    endcase
    write_reg(REG_ENABLE, en_word);
    write_reg(REG_DZ_RADIUS, radius);
    write_axis_cal(1'b0, random_axis_cal($urandom_range(0, 3)));
    write_axis_cal(1'b1, random_axis_cal($urandom_range(0, 3)));
  endtask

  task automatic random_samples(int count);
    repeat (count) send_sample(pick_sample(cal_x, cal_radius), pick_sample(cal_y, cal_radius));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset calibration: rest position and the corners of the sample range
  task automatic test_reset_calibration();
    send_sample(10'd444, 10'd532);
    send_sample(10'd0,    10'd0);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd0,    10'd1023);
    send_sample(10'd1023, 10'd0);
    drain_pipeline();
  endtask

  // An offset exactly on the radius is outside the deadzone, one less is inside
  task automatic test_deadzone_edge();
    send_sample(10'd508, 10'd532);
    send_sample(10'd507, 10'd532);
    send_sample(10'd444, 10'd468);
    drain_pipeline();
  endtask

  // Flat negative span on X, flat positive span on Y
  task automatic test_zero_divisor();
    write_axis_cal(1'b0, '{neg_end: 10'd500, center: 10'd500, pos_end: 10'd900});
    write_axis_cal(1'b1, '{neg_end: 10'd100, center: 10'd500, pos_end: 10'd500});
    send_sample(10'd100, 10'd900);
    send_sample(10'd900, 10'd100);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd0, 10'd0);
    drain_pipeline();
  endtask

  // Only bit 0 of the enable word counts
  task automatic test_disable();
    write_reg(REG_ENABLE, 10'h3FE);
    send_sample(10'd0, 10'd1023);
    send_sample(10'd1023, 10'd0);
    drain_pipeline();
    write_reg(REG_ENABLE, 10'h001);
    send_sample(10'd1023, 10'd0);
    drain_pipeline();
  endtask

  // No deadzone at all, then one that covers the whole range
  task automatic test_radius_extremes();
    write_reg(REG_DZ_RADIUS, 10'd0);
    send_sample(10'd500, 10'd500);
    send_sample(10'd1023, 10'd0);
    drain_pipeline();
    write_reg(REG_DZ_RADIUS, 10'd1023);
    send_sample(10'd1023, 10'd0);
    send_sample(10'd0, 10'd1023);
    drain_pipeline();
  endtask

  task automatic test_random_calibrations(int phases, int per_phase);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (phases) begin
      random_calibration();
      random_samples(per_phase);
      drain_pipeline();
    end
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // pipeline fills and the input stalls; then pause until all have drained
  task automatic test_output_stall();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    @(posedge clk_i);
    sink_hold_cycles = 80;
    @(negedge clk_i);
    random_samples(60);
    drain_pipeline();
  endtask

  // Back to back at full rate, no idling on either side
  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    random_calibration();
    write_reg(REG_ENABLE, 10'h001);
    random_samples(120);
    drain_pipeline();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ENABLE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cal_enable    = RST_ENABLE;
    cal_radius    = RST_DZ_RADIUS;
    cal_x         = RST_X_CAL;
    cal_y         = RST_Y_CAL;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_calibration();
    test_deadzone_edge();
    test_zero_divisor();
    test_disable();
    test_radius_extremes();
    test_random_calibrations(12, 60);
    test_output_stall();
    test_full_rate();

    // Let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_axes_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/jdas_pkg.sv
rtl/core/joystick_deadzone_axis_scaler.sv
tb/joystick_deadzone_axis_scaler_tb.sv
